FILE: sv/plid_pkg.sv
// Package for the positional list: request and response types, status codes,
// controller states and the command and status bundles between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 5;
   localparam int COUNT_W          = 5;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      action_type               action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] removed_value;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DEL_CAP,
      S_SCAN,
      S_SHIFT_WR
   } state_type;

   typedef struct packed {
      logic       load;
      logic       k_load_count;
      logic       k_load_pos;
      logic       k_step;
      logic       rd_en;
      logic       rd_pos;
      logic       wr_en;
      logic       wr_val;
      logic       cap_removed;
      logic       count_inc;
      logic       count_dec;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_delete;
      logic pos_bad;
      logic full;
      logic more;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/plid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module plid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/plid_ctrl.sv
// Controller for the positional list: sequences checking, entry shifting and the response.
// Depends on plid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plid_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire plid_pkg::dp_status_type dp_status,
   output plid_pkg::cmd_type            cmd,
   output logic                         busy
);

   plid_pkg::state_type state_ff;
   plid_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plid_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = plid_pkg::ST_DONE;
      case (state_ff)
         plid_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = plid_pkg::S_CHECK;
            end
         end
         plid_pkg::S_CHECK: begin
            // Position is checked before fullness, so a bad position wins.
            if (dp_status.pos_bad) begin
               cmd.respond = 1'b1;
               cmd.status  = plid_pkg::ST_BADPOS;
               state_in    = plid_pkg::S_IDLE;
            end else if (!dp_status.is_delete && dp_status.full) begin
               cmd.respond = 1'b1;
               cmd.status  = plid_pkg::ST_FULL;
               state_in    = plid_pkg::S_IDLE;
            end else if (dp_status.is_delete) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_pos = 1'b1;
               state_in   = plid_pkg::S_DEL_CAP;
            end else begin
               cmd.k_load_count = 1'b1;
               state_in         = plid_pkg::S_SCAN;
            end
         end
         plid_pkg::S_DEL_CAP: begin
            cmd.cap_removed = 1'b1;
            cmd.k_load_pos  = 1'b1;
            state_in        = plid_pkg::S_SCAN;
         end
         plid_pkg::S_SCAN: begin
            if (dp_status.more) begin
               cmd.rd_en = 1'b1;
               state_in  = plid_pkg::S_SHIFT_WR;
            end else begin
               // Shifting is finished: store the new word or drop the last slot.
               if (dp_status.is_delete) begin
                  cmd.count_dec = 1'b1;
               end else begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_val    = 1'b1;
                  cmd.count_inc = 1'b1;
               end
               cmd.respond = 1'b1;
               state_in    = plid_pkg::S_IDLE;
            end
         end
         plid_pkg::S_SHIFT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.k_step = 1'b1;
            state_in   = plid_pkg::S_SCAN;
         end
         default: begin
            state_in = plid_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != plid_pkg::S_IDLE);

endmodule

`default_nettype wire

FILE: sv/plid_dp.sv
// Datapath for the positional list: request latch, length count, shift pointer,
// entry RAM and response register. Depends on plid_pkg and plid_ram.
`timescale 1ns / 1ps
`default_nettype none

module plid_dp #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire plid_pkg::req_type       req_item,
   input  wire plid_pkg::cmd_type       cmd,
   output plid_pkg::dp_status_type      dp_status,
   output logic                         rsp_strobe,
   output plid_pkg::rsp_type            rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int MW = ((CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W) + 1;

   plid_pkg::action_type             act_ff;
   logic [plid_pkg::POS_W-1:0]       pos_ff;
   logic signed [plid_pkg::DATA_W-1:0] val_ff;
   logic signed [plid_pkg::DATA_W-1:0] removed_ff;
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;
   logic [CW-1:0]                    k_ff;
   logic [CW-1:0]                    k_in;
   logic [CW-1:0]                    k_m1;
   logic                             rsp_strobe_ff;
   plid_pkg::rsp_type                rsp_ff;
   plid_pkg::rsp_type                rsp_in;

   logic [MW-1:0]                    pos_ext;
   logic [MW-1:0]                    pos_m1;
   logic [MW-1:0]                    count_ext;
   logic [MW-1:0]                    count_in_ext;
   logic [MW-1:0]                    k_ext;
   logic                             is_del;

   logic [AW-1:0]                    rd_addr;
   logic [AW-1:0]                    wr_addr;
   logic [plid_pkg::DATA_W-1:0]      wr_data;
   logic [plid_pkg::DATA_W-1:0]      rd_data;

   assign is_del    = (act_ff == plid_pkg::ACT_DELETE);
   assign pos_ext   = MW'(pos_ff);
   assign pos_m1    = pos_ext - MW'(1);
   assign count_ext = MW'(count_ff);
   assign k_ext     = MW'(k_ff);
   assign k_m1      = k_ff - CW'(1);

   always_comb begin
      dp_status.is_delete = is_del;
      if (is_del) begin
         dp_status.pos_bad = (pos_ff == '0) || (pos_ext > count_ext);
         dp_status.more    = (k_ext < count_ext);
      end else begin
         dp_status.pos_bad = (pos_ff == '0) || (pos_ext > (count_ext + MW'(1)));
         dp_status.more    = (k_ext >= pos_ext);
      end
      dp_status.full = (count_ff == CW'(CAPACITY));
   end

   // Insert walks down from the top, reading k-1 into k; delete walks up,
   // reading k into k-1.
   always_comb begin
      if (cmd.rd_pos) begin
         rd_addr = pos_m1[AW-1:0];
      end else if (is_del) begin
         rd_addr = k_ff[AW-1:0];
      end else begin
         rd_addr = k_m1[AW-1:0];
      end
      if (cmd.wr_val || !is_del) begin
         wr_addr = k_ff[AW-1:0];
      end else begin
         wr_addr = k_m1[AW-1:0];
      end
      wr_data = cmd.wr_val ? val_ff : rd_data;
   end

   plid_ram #(
      .WIDTH (plid_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      k_in = k_ff;
      if (cmd.k_load_count) begin
         k_in = count_ff;
      end else if (cmd.k_load_pos) begin
         k_in = pos_ext[CW-1:0];
      end else if (cmd.k_step) begin
         k_in = is_del ? (k_ff + CW'(1)) : k_m1;
      end

      count_in_ext         = MW'(count_in);
      rsp_in.status        = cmd.status;
      rsp_in.removed_value = removed_ff;
      rsp_in.count         = count_in_ext[plid_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load) begin
         act_ff     <= req_item.action;
         pos_ff     <= req_item.position;
         val_ff     <= req_item.value;
         removed_ff <= '0;
      end else if (cmd.cap_removed) begin
         removed_ff <= rd_data;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/positional_list_insert_delete.sv
// Top level of the positional list: insert and delete of signed words at a
// 1-based position. Depends on plid_pkg, plid_ctrl and plid_dp.
//
//   Channel    Ports                          Handshake
//   request    start, busy, req_item          taken when start is high and busy is low
//   response   rsp_strobe, rsp_item           valid for one cycle, cannot be held off
//
// A rejected request is answered from the check state, with no shifting. An
// insert at position p shifts the entries from p up by one slot, a delete the
// entries after p down by one: every entry moved costs a read state and a write
// state, as the entry RAM has a registered read port.
// A new request may be accepted in the cycle the strobe shows.
// Reset clears the length and the controller; entry contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire plid_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output plid_pkg::rsp_type      rsp_item
);

   plid_pkg::cmd_type       cmd;
   plid_pkg::dp_status_type dp_status;

   plid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   plid_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

FILE: sv/plid_checker.sv
// Port-level checks for the positional list, bound to the top level.
// Depends on plid_pkg and positional_list_insert_delete.
`timescale 1ns / 1ps
`default_nettype none

module plid_checker #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire plid_pkg::rsp_type rsp_item
);

   localparam logic [plid_pkg::COUNT_W-1:0] CAP_COUNT = plid_pkg::COUNT_W'(CAPACITY);

   // An accepted request always raises busy in the cycle after acceptance.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Responses never come in consecutive cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   // A rejected request removes nothing.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != plid_pkg::ST_DONE) |-> (rsp_item.removed_value == '0))
      else $error("rejected request reported a removed word");

   // A full rejection reports the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == plid_pkg::ST_FULL) |-> (rsp_item.count == CAP_COUNT))
      else $error("full status with a count below capacity");

   // Reset leaves the block idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

endmodule

bind positional_list_insert_delete plid_checker #(
   .CAPACITY (CAPACITY)
) u_plid_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
